// File: sv/ffsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types, codes and defaults of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int DEF_TABLE_ENTRIES = 256;
    localparam int DEF_PAGE_BYTES    = 4096;

    // operation codes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_HEADS = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_GAP   = 2'd1;
    localparam logic [1:0] ST_NO_FREE  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] req_bytes;
        logic [7:0]  entry_index;
        logic [31:0] entry_base;
        logic [31:0] entry_size;
        logic [7:0]  entry_next;
        logic [7:0]  head_first;
        logic [7:0]  head_free;
    } cmd_t;

    typedef struct packed {
        logic [31:0] alloc_base;
        logic [1:0]  status;
        logic [7:0]  new_index;
        logic [7:0]  segment_count;
    } res_t;

    // one table entry
    typedef struct packed {
        logic [31:0] base;
        logic [31:0] len;
        logic [7:0]  next;
    } seg_t;

    // per-field write enables of the table
    typedef struct packed {
        logic base;
        logic len;
        logic next;
    } seg_we_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FIRST,
        S_WALK,
        S_TAKE,
        S_LINK
    } state_t;

endpackage
`default_nettype wire

// File: sv/ffsa_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_mem
// Segment table: one write port with per-field enables, one registered read.
// ----------------------------------------------------------------------------
module ffsa_mem
    import ffsa_pkg::*;
#(
    parameter int DEPTH = DEF_TABLE_ENTRIES,
    parameter int AW    = $clog2(DEPTH)
)(
    input  wire logic          clk,
    input  wire seg_we_t       we,
    input  wire logic [AW-1:0] wr_addr,
    input  wire seg_t          wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output seg_t               rd_data
);

    logic [31:0] base_mem [DEPTH];
    logic [31:0] len_mem  [DEPTH];
    logic [7:0]  next_mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we.base)
        begin
            base_mem[wr_addr] <= wr_data.base;
        end
        if (we.len)
        begin
            len_mem[wr_addr] <= wr_data.len;
        end
        if (we.next)
        begin
            next_mem[wr_addr] <= wr_data.next;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data.base <= base_mem[rd_addr];
            rd_data.len  <= len_mem[rd_addr];
            rd_data.next <= next_mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: sv/ffsa_round.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_round
// Rounds a request up to whole pages and adds padding. The page size is a
// power of two, so rounding is an add and a mask. The rounded size is
// registered, then the padding is added and a carry out of 32 bits flagged.
// ----------------------------------------------------------------------------
module ffsa_round
    import ffsa_pkg::*;
#(
    parameter int PAGE_BYTES = DEF_PAGE_BYTES
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        go,
    input  wire logic [31:0] req,
    input  wire logic [31:0] pad,
    output logic             done,
    output logic [31:0]      size,
    output logic             ovf
);

    localparam logic [32:0] PAGE_MASK = 33'(PAGE_BYTES - 1);

    logic          stage_reg;
    logic          done_reg;
    logic [32:0]   rnd_reg;
    logic [31:0]   size_reg;
    logic          ovf_reg;

    logic [32:0]   rnd_next;
    logic [33:0]   padded;

    // round up at 33 bits, then pad at 34 bits
    always_comb
    begin
        rnd_next = ({1'b0, req} + PAGE_MASK) & ~PAGE_MASK;
        padded   = {1'b0, rnd_reg} + {2'b00, pad};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= go;
            done_reg  <= stage_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rnd_reg <= rnd_next;
        end
        if (stage_reg)
        begin
            size_reg <= padded[31:0];
            ovf_reg  <= (padded[33:32] != 2'b00);
        end
    end

    assign done = done_reg;
    assign size = size_reg;
    assign ovf  = ovf_reg;

endmodule
`default_nettype wire

// File: sv/first_fit_segment_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_unit
// First-fit allocator over a linked segment table held in block memory.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake            Word
// command   in   start && !busy       cmd (cmd_t)
// result    out  done, one cycle      result (res_t)
// config    in   cfg_we               cfg_wdata (pad bytes)
//
// Load, set heads and no-op finish in idle; the result shows the next cycle.
// Allocate: page rounding and padding, a read of the first entry, one table
// read per gap tested (up to TABLE_ENTRIES gaps), then the take and link
// write-back steps. PAGE_BYTES must be a power of two.
// Reset clears state, done, heads, count and pad only; the table is undefined until loaded.
// The result port cannot stall; busy holds off new commands during allocate.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_unit
    import ffsa_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int PAGE_BYTES    = DEF_PAGE_BYTES
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire cmd_t        cmd,
    output logic             done,
    output res_t             result,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int SW = $clog2(TABLE_ENTRIES + 1);

    state_t      state_reg, state_next;
    logic [31:0] pad_reg;
    logic [7:0]  first_reg, first_next;
    logic [7:0]  free_reg, free_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  cur_idx_reg, cur_idx_next;
    logic [7:0]  cur_nx_reg, cur_nx_next;
    logic [32:0] cur_end_reg, cur_end_next;
    logic [7:0]  take_reg, take_next;
    logic [31:0] size_reg, size_next;
    logic [SW-1:0] steps_reg, steps_next;
    logic        done_reg, done_next;
    res_t        res_reg, res_next;
    logic        rd_ok_reg;

    logic        round_go;
    logic        round_done;
    logic [31:0] round_size;
    logic        round_ovf;

    seg_we_t     mem_we;
    logic [7:0]  wr_idx;
    seg_t        wr_data;
    logic        rd_en;
    logic [7:0]  rd_idx;
    seg_t        rd_raw;
    seg_t        rd_seg;
    logic [31:0] wr_idx32;
    logic [31:0] rd_idx32;
    logic [31:0] free32;
    logic        free_ok;
    logic        rd_in_tab;
    logic [33:0] need_end;
    logic        fit;

    assign wr_idx32  = 32'(wr_idx);
    assign rd_idx32  = 32'(rd_idx);
    assign free32    = 32'(free_reg);
    assign free_ok   = (free_reg != 8'd0) && (free32 < 32'(TABLE_ENTRIES));
    assign rd_in_tab = rd_idx32 < 32'(TABLE_ENTRIES);

    // out-of-table reads see an entry of zeros
    assign rd_seg = rd_ok_reg ? rd_raw : '0;

    // gap test at full width
    assign need_end = {1'b0, cur_end_reg} + {2'b00, size_reg};
    assign fit      = need_end <= {2'b00, rd_seg.base};

    ffsa_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (wr_idx32[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx32[AW-1:0]),
        .rd_data (rd_raw)
    );

    ffsa_round #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (round_go),
        .req   (cmd.req_bytes),
        .pad   (pad_reg),
        .done  (round_done),
        .size  (round_size),
        .ovf   (round_ovf)
    );

    // next state and datapath control
    always_comb
    begin
        state_next   = state_reg;
        first_next   = first_reg;
        free_next    = free_reg;
        count_next   = count_reg;
        cur_idx_next = cur_idx_reg;
        cur_nx_next  = cur_nx_reg;
        cur_end_next = cur_end_reg;
        take_next    = take_reg;
        size_next    = size_reg;
        steps_next   = steps_reg;
        done_next    = 1'b0;
        res_next     = res_reg;
        round_go     = 1'b0;
        mem_we       = '0;
        wr_idx       = cmd.entry_index;
        wr_data      = '{base: cmd.entry_base, len: cmd.entry_size, next: cmd.entry_next};
        rd_en        = 1'b0;
        rd_idx       = first_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    res_next = '{alloc_base: 32'd0, status: ST_OK, new_index: 8'd0,
                                 segment_count: count_reg};
                    unique case (cmd.op)
                        OP_ALLOC:
                        begin
                            round_go   = 1'b1;
                            state_next = S_ROUND;
                        end
                        OP_LOAD:
                        begin
                            if (cmd.entry_index != 8'd0 && wr_idx32 < 32'(TABLE_ENTRIES))
                            begin
                                mem_we = '{base: 1'b1, len: 1'b1, next: 1'b1};
                            end
                            done_next = 1'b1;
                        end
                        OP_HEADS:
                        begin
                            first_next = cmd.head_first;
                            free_next  = cmd.head_free;
                            done_next  = 1'b1;
                        end
                        OP_NOP:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_ROUND:
            begin
                if (round_done)
                begin
                    size_next = round_size;
                    if (round_ovf)
                    begin
                        res_next.status = ST_OVERFLOW;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else if (first_reg == 8'd0)
                    begin
                        res_next.status = ST_NO_GAP;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        rd_en        = 1'b1;
                        rd_idx       = first_reg;
                        cur_idx_next = first_reg;
                        state_next   = S_FIRST;
                    end
                end
            end

            S_FIRST:
            begin
                if (rd_seg.next == 8'd0)
                begin
                    res_next.status = ST_NO_GAP;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cur_end_next = {1'b0, rd_seg.base} + {1'b0, rd_seg.len};
                    cur_nx_next  = rd_seg.next;
                    steps_next   = '0;
                    rd_en        = 1'b1;
                    rd_idx       = rd_seg.next;
                    state_next   = S_WALK;
                end
            end

            // rd_seg holds the entry that follows the current segment
            S_WALK:
            begin
                if (fit)
                begin
                    if (!free_ok)
                    begin
                        res_next.status = ST_NO_FREE;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        take_next  = free_reg;
                        rd_en      = 1'b1;
                        rd_idx     = free_reg;
                        state_next = S_TAKE;
                    end
                end
                else if (steps_reg == SW'(TABLE_ENTRIES - 1) || rd_seg.next == 8'd0)
                begin
                    res_next.status = ST_NO_GAP;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cur_idx_next = cur_nx_reg;
                    cur_end_next = {1'b0, rd_seg.base} + {1'b0, rd_seg.len};
                    cur_nx_next  = rd_seg.next;
                    steps_next   = steps_reg + SW'(1);
                    rd_en        = 1'b1;
                    rd_idx       = rd_seg.next;
                end
            end

            // pop the free entry and fill it in
            S_TAKE:
            begin
                free_next  = rd_seg.next;
                mem_we     = '{base: 1'b1, len: 1'b1, next: 1'b1};
                wr_idx     = take_reg;
                wr_data    = '{base: cur_end_reg[31:0], len: size_reg, next: cur_nx_reg};
                state_next = S_LINK;
            end

            // link the new entry after the current segment
            S_LINK:
            begin
                mem_we       = '{base: 1'b0, len: 1'b0, next: 1'b1};
                wr_idx       = cur_idx_reg;
                wr_data      = '{base: 32'd0, len: 32'd0, next: take_reg};
                count_next   = (count_reg == 8'hFF) ? count_reg : count_reg + 8'd1;
                res_next     = '{alloc_base: cur_end_reg[31:0], status: ST_OK,
                                 new_index: take_reg, segment_count: count_next};
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pad_reg   <= '0;
            first_reg <= '0;
            free_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            free_reg  <= free_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                pad_reg <= cfg_wdata;
            end
        end
    end

    // walk datapath
    always_ff @(posedge clk)
    begin
        cur_idx_reg <= cur_idx_next;
        cur_nx_reg  <= cur_nx_next;
        cur_end_reg <= cur_end_next;
        take_reg    <= take_next;
        size_reg    <= size_next;
        steps_reg   <= steps_next;
        res_reg     <= res_next;
        if (rd_en)
        begin
            rd_ok_reg <= rd_in_tab;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // checks
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |-> result.alloc_base == 32'd0
                                          && result.new_index == 8'd0)
        else $error("failed allocate carries base or index");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> steps_reg < SW'(TABLE_ENTRIES))
        else $error("walk exceeded table size");

    a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we != '0) |-> (state_reg == S_TAKE || state_reg == S_LINK
                            || (state_reg == S_IDLE && start && cmd.op == OP_LOAD)))
        else $error("table written outside load or allocate write-back");

    a_count_src: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> $past(state_reg) == S_LINK)
        else $error("segment count changed without an allocation");

    a_take_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TAKE |=> state_reg == S_LINK ##1 done)
        else $error("allocation write-back did not complete");

endmodule
`default_nettype wire
